// File: design/afc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ADC conversion frame checker.
// No dependencies; every other design file except afc_fifo imports this package.
package afc_pkg;

  // Configuration register indexes on the write port
  localparam logic [2:0] CFG_CKS_MASK = 3'd0;
  localparam logic [2:0] CFG_CHAN_MAP = 3'd1;
  localparam logic [2:0] CFG_MAX_CODE = 3'd2;
  localparam logic [2:0] CFG_MIN_CODE = 3'd3;
  localparam logic [2:0] CFG_THRESH   = 3'd4;

  // Result status codes
  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_LINK  = 3'd1;
  localparam logic [2:0] STAT_CKS   = 3'd2;
  localparam logic [2:0] STAT_CHAN  = 3'd3;
  localparam logic [2:0] STAT_RANGE = 3'd4;

  // Register reset values
  localparam logic [1:0]         RST_CKS_MASK = 2'd0;
  localparam logic [1:0]         RST_CHAN_MAP = 2'd1;
  localparam logic signed [30:0] RST_MAX_CODE = 31'sh3FFF_FFFF;
  localparam logic signed [30:0] RST_MIN_CODE = 31'sh4000_0000;
  localparam logic [7:0]         RST_THRESH   = 8'd200;

  localparam logic [7:0]         CKS_SEED = 8'h5A;
  localparam logic [7:0]         FAIL_MAX = 8'hFF;
  localparam logic signed [23:0] CODE_MAX = 24'sh7F_FFFF;
  localparam logic signed [23:0] CODE_MIN = 24'sh80_0000;

  localparam int DEFAULT_NUM_CHIPS = 2;
  localparam int QUEUE_DEPTH       = 2;

  // Front-side configuration seen by the classifier
  typedef struct packed {
    logic [1:0]         cks_mask;
    logic [1:0]         chan_map;
    logic signed [30:0] max_code;
    logic signed [30:0] min_code;
  } afc_cfg_t;

  // Classified frame passed from the front to the back
  typedef struct packed {
    logic               chip;
    logic               hold;    // chip out of range: leave failure counts alone
    logic [2:0]         status;
    logic signed [23:0] code;
    logic               chan;
  } afc_item_t;

  // Finished result
  typedef struct packed {
    logic [2:0]         status;
    logic signed [23:0] code;
    logic               chan;
    logic               restart;
  } afc_result_t;

endpackage

// File: design/afc_fifo.sv
`timescale 1ns / 1ps
// Small register-based FIFO used between the front, the back and the result ports.
// No package dependency.
module afc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// File: design/afc_front.sv
`timescale 1ns / 1ps
// Front classifier: link, checksum, channel and range checks on one incoming frame.
// Depends on afc_pkg.
module afc_front #(
  parameter int NUM_CHIPS = afc_pkg::DEFAULT_NUM_CHIPS
) (
  input  logic              chip,
  input  logic [31:0]       frame_word,
  input  logic [7:0]        check_byte,
  input  logic              link_ok,
  input  afc_pkg::afc_cfg_t cfg,
  output afc_pkg::afc_item_t item
);
  import afc_pkg::*;

  logic               chip_ok;
  logic [7:0]         sum;
  logic signed [30:0] val;
  logic signed [30:0] max_code;
  logic signed [30:0] min_code;
  logic signed [24:0] shifted;
  logic signed [23:0] sat_code;

  assign chip_ok  = (NUM_CHIPS > 1) || (chip == 1'b0);
  assign sum      = frame_word[31:24] + frame_word[23:16] + frame_word[15:8]
                  + frame_word[7:0] + CKS_SEED;
  assign val      = frame_word[31:1];
  assign max_code = cfg.max_code;
  assign min_code = cfg.min_code;
  assign shifted  = val[30:6];

  // Clamp the 25-bit shifted value into the signed 24-bit code range
  always_comb begin
    if (shifted[24] != shifted[23]) begin
      sat_code = shifted[24] ? CODE_MIN : CODE_MAX;
    end else begin
      sat_code = shifted[23:0];
    end
  end

  always_comb begin
    item.chip   = chip;
    item.hold   = !chip_ok;
    item.status = STAT_OK;
    item.code   = '0;
    item.chan   = 1'b0;
    if (!chip_ok || !link_ok) begin
      item.status = STAT_LINK;
    end else if (cfg.cks_mask[chip] && (sum != check_byte)) begin
      item.status = STAT_CKS;
    end else begin
      item.chan = frame_word[0];
      if (frame_word[0] != cfg.chan_map[chip]) begin
        item.status = STAT_CHAN;
      end else if ((val > max_code) || (val < min_code)) begin
        item.status = STAT_RANGE;
      end else begin
        item.code = sat_code;
      end
    end
  end

endmodule

// File: design/afc_back.sv
`timescale 1ns / 1ps
// Back end: per-chip checksum failure counts and restart requests.
// Depends on afc_pkg.
module afc_back #(
  parameter int NUM_CHIPS = afc_pkg::DEFAULT_NUM_CHIPS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  afc_pkg::afc_item_t   item,
  output logic                 take,
  input  logic                 out_full,
  input  logic [7:0]           threshold,
  output afc_pkg::afc_result_t result
);
  import afc_pkg::*;

  logic [7:0] fail_count [NUM_CHIPS];
  logic [7:0] cur;
  logic [7:0] inc;
  logic       hit;
  logic [7:0] cks_count;
  logic       is_cks;

  assign take = in_valid && !out_full;

  always_comb begin
    cur = '0;
    for (int c = 0; c < NUM_CHIPS; c++) begin
      if (c == int'(item.chip)) begin
        cur = fail_count[c];
      end
    end
  end

  assign is_cks    = (item.status == STAT_CKS);
  assign inc       = (cur == FAIL_MAX) ? cur : cur + 8'd1;
  assign hit       = (inc >= threshold);
  assign cks_count = hit ? 8'd0 : inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHIPS; c++) begin
        fail_count[c] <= '0;
      end
    end else if (take && !item.hold) begin
      for (int c = 0; c < NUM_CHIPS; c++) begin
        if (c == int'(item.chip)) begin
          fail_count[c] <= is_cks ? cks_count : 8'd0;
        end
      end
    end
  end

  always_comb begin
    result.status  = item.status;
    result.code    = item.code;
    result.chan    = item.chan;
    result.restart = is_cks && hit;
  end

endmodule

// File: design/adc_conversion_frame_checker.sv
`timescale 1ns / 1ps
// Top level of the ADC conversion frame checker. Depends on afc_pkg, afc_front,
// afc_fifo and afc_back.
// A frame passes through the input queue, the back end and the result queue to the result ports.
// Throughput: one frame per cycle while the result queue has room; the count update is registered.
// Reset: synchronous, active high; clears queues and failure counts, loads config reset values.
module adc_conversion_frame_checker #(
  parameter int NUM_CHIPS = afc_pkg::DEFAULT_NUM_CHIPS
) (
  input  logic               clk,
  input  logic               rst,
  // frame input, queue style
  input  logic               push,
  output logic               full,
  input  logic               chip,
  input  logic [31:0]        frame_word,
  input  logic [7:0]         check_byte,
  input  logic               link_ok,
  // result output, queue style
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status,
  output logic signed [23:0] code,
  output logic               channel,
  output logic               restart_request,
  // configuration writes
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [30:0]        wr_data
);
  import afc_pkg::*;

  localparam int ITEM_W = $bits(afc_item_t);
  localparam int RES_W  = $bits(afc_result_t);

  // Configuration registers
  logic [1:0]         cks_mask;
  logic [1:0]         chan_map;
  logic signed [30:0] max_code;
  logic signed [30:0] min_code;
  logic [7:0]         threshold;

  afc_cfg_t    cfg;
  afc_item_t   front_item;
  afc_item_t   mid_item;
  afc_result_t back_result;
  afc_result_t out_result;

  logic [ITEM_W-1:0] mid_dout;
  logic [RES_W-1:0]  out_dout;
  logic              mid_empty;
  logic              back_take;
  logic              out_full;

  // Decode a write into the addressed register; indexes past the list drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      cks_mask  <= RST_CKS_MASK;
      chan_map  <= RST_CHAN_MAP;
      max_code  <= RST_MAX_CODE;
      min_code  <= RST_MIN_CODE;
      threshold <= RST_THRESH;
    end else if (wr_en) begin
      case (wr_index)
        CFG_CKS_MASK: cks_mask  <= wr_data[1:0];
        CFG_CHAN_MAP: chan_map  <= wr_data[1:0];
        CFG_MAX_CODE: max_code  <= wr_data;
        CFG_MIN_CODE: min_code  <= wr_data;
        CFG_THRESH:   threshold <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg.cks_mask = cks_mask;
  assign cfg.chan_map = chan_map;
  assign cfg.max_code = max_code;
  assign cfg.min_code = min_code;

  // Classify the incoming transaction on the fly; the queue below registers it
  afc_front #(
    .NUM_CHIPS(NUM_CHIPS)
  ) u_front (
    .chip      (chip),
    .frame_word(frame_word),
    .check_byte(check_byte),
    .link_ok   (link_ok),
    .cfg       (cfg),
    .item      (front_item)
  );

  // Hold classified frames so the front keeps accepting while the back stalls
  afc_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (front_item),
    .full (full),
    .pop  (back_take),
    .dout (mid_dout),
    .empty(mid_empty)
  );

  assign mid_item = afc_item_t'(mid_dout);

  // Advance one classified frame per cycle through the failure counters while the result queue has room
  afc_back #(
    .NUM_CHIPS(NUM_CHIPS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!mid_empty),
    .item     (mid_item),
    .take     (back_take),
    .out_full (out_full),
    .threshold(threshold),
    .result   (back_result)
  );

  // Result queue: hold finished results until the consumer pops them
  afc_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (back_take),
    .din  (back_result),
    .full (out_full),
    .pop  (pop),
    .dout (out_dout),
    .empty(empty)
  );

  assign out_result      = afc_result_t'(out_dout);
  assign status          = out_result.status;
  assign code            = out_result.code;
  assign channel         = out_result.chan;
  assign restart_request = out_result.restart;

endmodule

// File: design/afc_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the ADC conversion frame checker, bound to the top.
// Depends on afc_pkg and adc_conversion_frame_checker.
module afc_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  status,
  input logic [23:0] code,
  input logic        channel,
  input logic        restart_request
);
  import afc_pkg::*;

  // Reset drains both queues
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not drained after reset");

  // A waiting result must hold until popped
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(code)
                          && $stable(channel) && $stable(restart_request)))
    else $error("waiting result changed before pop");

  // Restart requests only come with checksum failures
  a_restart_cks: assert property (@(posedge clk) disable iff (rst)
    (!empty && restart_request) |-> (status == STAT_CKS))
    else $error("restart request without checksum failure");

  // Rejected frames carry no code
  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status != STAT_OK)) |-> (code == '0))
    else $error("nonzero code on rejected frame");

  // Link and checksum errors report no channel
  a_chan_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && ((status == STAT_LINK) || (status == STAT_CKS))) |-> !channel)
    else $error("channel reported on link or checksum error");

endmodule

bind adc_conversion_frame_checker afc_checker u_afc_checker (.*);
